// ===== rtl/core/fdg_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// fdg_pkg
// Shared widths, codes, item types and helpers of the forward-difference
// gradient frame store.
// ============================================================================
package fdg_pkg;

   localparam int MAX_POINTS     = 4096;
   localparam int IDX_BITS       = $clog2(MAX_POINTS);
   localparam int ADDR_BITS      = IDX_BITS + 2;       // neighbor address, may pass the store
   localparam int DIM_BITS       = 13;
   localparam int VALUE_BITS     = 24;
   localparam int SAMPLE_BITS    = 24;
   localparam int PRIOR_BITS     = 28;
   localparam int OUT_BITS       = 28;
   localparam int ACC_BITS       = 30;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 13;
   localparam int Q_DEPTH        = 2;
   localparam int Q_PTR_BITS     = $clog2(Q_DEPTH);
   localparam int Q_COUNT_BITS   = $clog2(Q_DEPTH + 1);
   localparam int DIV_COUNT_BITS = $clog2(IDX_BITS + 1);

   // configuration register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_WIDTH     = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_HEIGHT    = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ADJOINT_MODE    = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ACCUMULATE_MODE = 2'd3;

   localparam logic [DIM_BITS-1:0] FRAME_WIDTH_RESET  = DIM_BITS'(64);
   localparam logic [DIM_BITS-1:0] FRAME_HEIGHT_RESET = DIM_BITS'(64);

   // request opcodes
   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_READ  = 1'b1;

   // classification done by the front end
   localparam logic [1:0] KIND_RANGE = 2'd0;
   localparam logic [1:0] KIND_WRITE = 2'd1;
   localparam logic [1:0] KIND_READ  = 2'd2;

   localparam logic STATUS_DONE  = 1'b0;
   localparam logic STATUS_RANGE = 1'b1;

   typedef struct packed {
      logic                          op;
      logic [IDX_BITS-1:0]           index;
      logic signed [VALUE_BITS-1:0]  value_a;
      logic signed [VALUE_BITS-1:0]  value_b;
      logic signed [PRIOR_BITS-1:0]  prior_a;
      logic signed [PRIOR_BITS-1:0]  prior_b;
   } req_item_type;

   typedef struct packed {
      logic [1:0]                    kind;
      logic [IDX_BITS-1:0]           index;
      logic signed [VALUE_BITS-1:0]  value_a;
      logic signed [VALUE_BITS-1:0]  value_b;
      logic signed [PRIOR_BITS-1:0]  prior_a;
      logic signed [PRIOR_BITS-1:0]  prior_b;
   } item_type;

   typedef struct packed {
      logic signed [OUT_BITS-1:0]    grad_a;
      logic signed [OUT_BITS-1:0]    grad_b;
      logic                          status;
   } result_type;

   // clamp accumulator to the output range
   function automatic logic signed [OUT_BITS-1:0] sat_out(input logic signed [ACC_BITS-1:0] v);
      logic [ACC_BITS-OUT_BITS:0] top;
      top = v[ACC_BITS-1:OUT_BITS-1];
      if ((&top) || !(|top)) begin
         return v[OUT_BITS-1:0];
      end else if (v[ACC_BITS-1]) begin
         return {1'b1, {(OUT_BITS-1){1'b0}}};
      end else begin
         return {1'b0, {(OUT_BITS-1){1'b1}}};
      end
   endfunction

endpackage

// ===== rtl/core/fdg_front.sv =====
`timescale 1ns / 1ps
// ============================================================================
// fdg_front
// Input stage: registers a request, checks its index against the frame and
// tags it as write, read or out-of-range before it enters the work queue.
// ============================================================================
module fdg_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_push,
   output logic                          in_full,
   input  fdg_pkg::req_item_type         in_item,
   input  logic [fdg_pkg::DIM_BITS-1:0]  frame_width,
   input  logic [fdg_pkg::DIM_BITS-1:0]  frame_height,
   output logic                          q_push,
   input  logic                          q_full,
   output fdg_pkg::item_type             q_item
);
   import fdg_pkg::*;

   logic                        stage_valid_ff, stage_valid_in;
   req_item_type                stage_ff;
   logic                        advance;
   logic [2*DIM_BITS-1:0]       frame_points;
   logic [2*DIM_BITS-1:0]       index_wide;
   logic                        out_range;

   assign advance = !stage_valid_ff || !q_full;
   assign in_full = !advance;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (advance) begin
         stage_valid_in = in_push;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_push) begin
         stage_ff <= in_item;
      end
   end

   assign frame_points = frame_width * frame_height;
   assign index_wide   = {{(2*DIM_BITS-IDX_BITS){1'b0}}, stage_ff.index};
   assign out_range    = index_wide >= frame_points;

   always_comb begin
      q_item.index   = stage_ff.index;
      q_item.value_a = stage_ff.value_a;
      q_item.value_b = stage_ff.value_b;
      q_item.prior_a = stage_ff.prior_a;
      q_item.prior_b = stage_ff.prior_b;
      if (out_range) begin
         q_item.kind = KIND_RANGE;
      end else if (stage_ff.op == REQ_READ) begin
         q_item.kind = KIND_READ;
      end else begin
         q_item.kind = KIND_WRITE;
      end
   end

   assign q_push = stage_valid_ff;

endmodule

// ===== rtl/core/fdg_queue.sv =====
`timescale 1ns / 1ps
// ============================================================================
// fdg_queue
// Short queue of classified requests between front end and back end.
// ============================================================================
module fdg_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  fdg_pkg::item_type  push_item,
   output logic               full,
   input  logic               pop,
   output logic               empty,
   output fdg_pkg::item_type  head
);
   import fdg_pkg::*;

   item_type                 slots [Q_DEPTH];
   logic [Q_PTR_BITS-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_BITS-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [Q_COUNT_BITS-1:0]  count_ff, count_in;
   logic                     do_push, do_pop;

   assign full    = count_ff == Q_COUNT_BITS'(Q_DEPTH);
   assign empty   = count_ff == '0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = slots[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == Q_PTR_BITS'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == Q_PTR_BITS'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== rtl/core/fdg_divider.sv =====
`timescale 1ns / 1ps
// ============================================================================
// fdg_divider
// Restoring divider, one quotient bit per cycle: splits a linear index into
// row (quotient) and column (remainder) by the frame width.
// ============================================================================
module fdg_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [fdg_pkg::IDX_BITS-1:0]  dividend,
   input  logic [fdg_pkg::DIM_BITS-1:0]  divisor,
   output logic                          done,
   output logic [fdg_pkg::IDX_BITS-1:0]  quotient,
   output logic [fdg_pkg::IDX_BITS-1:0]  remainder
);
   import fdg_pkg::*;

   logic [DIM_BITS-1:0]        rem_ff, rem_in;
   logic [IDX_BITS-1:0]        quo_ff, quo_in;
   logic [DIV_COUNT_BITS-1:0]  count_ff, count_in;
   logic                       done_ff, done_in;
   logic [DIM_BITS-1:0]        shifted;
   logic                       fits;

   // partial remainder stays below the divisor, so one shifted-in bit fits
   assign shifted = {rem_ff[DIM_BITS-2:0], quo_ff[IDX_BITS-1]};
   assign fits    = shifted >= divisor;

   always_comb begin
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      count_in = count_ff;
      done_in  = 1'b0;
      if (start) begin
         rem_in   = '0;
         quo_in   = dividend;
         count_in = DIV_COUNT_BITS'(IDX_BITS);
      end else if (count_ff != '0) begin
         rem_in   = fits ? shifted - divisor : shifted;
         quo_in   = {quo_ff[IDX_BITS-2:0], fits};
         count_in = count_ff - 1'b1;
         done_in  = count_ff == DIV_COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff[IDX_BITS-1:0];

endmodule

// ===== rtl/core/fdg_back.sv =====
`timescale 1ns / 1ps
// ============================================================================
// fdg_back
// Execution side: sample stores, row/column split, neighbor read sequence,
// accumulation with saturation and the result register.
// ============================================================================
module fdg_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_empty,
   input  fdg_pkg::item_type             q_head,
   output logic                          q_pop,
   input  logic [fdg_pkg::DIM_BITS-1:0]  frame_width,
   input  logic [fdg_pkg::DIM_BITS-1:0]  frame_height,
   input  logic                          adjoint_mode,
   input  logic                          accumulate_mode,
   output logic                          div_start,
   output logic [fdg_pkg::IDX_BITS-1:0]  div_dividend,
   input  logic                          div_done,
   input  logic [fdg_pkg::IDX_BITS-1:0]  div_quotient,
   input  logic [fdg_pkg::IDX_BITS-1:0]  div_remainder,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output fdg_pkg::result_type           rsp
);
   import fdg_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DIVIDE = 3'd1;
   localparam logic [2:0] ST_READ   = 3'd2;
   localparam logic [2:0] ST_DRAIN  = 3'd3;
   localparam logic [2:0] ST_DONE   = 3'd4;

   localparam logic [1:0] TERM_NONE = 2'd0;
   localparam logic [1:0] TERM_ADD  = 2'd1;
   localparam logic [1:0] TERM_SUB  = 2'd2;

   localparam logic [1:0] STEP_LAST = 2'd2;

   function automatic logic signed [ACC_BITS-1:0] term(
      input logic signed [SAMPLE_BITS-1:0] data,
      input logic                          zero,
      input logic [1:0]                    op
   );
      logic signed [ACC_BITS-1:0] ext;
      ext = zero ? '0 : {{(ACC_BITS-SAMPLE_BITS){data[SAMPLE_BITS-1]}}, data};
      unique case (op)
         TERM_ADD: return ext;
         TERM_SUB: return -ext;
         default:  return '0;
      endcase
   endfunction

   logic signed [SAMPLE_BITS-1:0] store_first  [MAX_POINTS];
   logic signed [SAMPLE_BITS-1:0] store_second [MAX_POINTS];

   logic [2:0]                    state_ff, state_in;
   logic [1:0]                    step_ff, step_in;
   logic [IDX_BITS-1:0]           index_ff, index_in;
   logic                          inner_ff, inner_in;
   logic                          has_left_ff, has_left_in;
   logic                          has_up_ff, has_up_in;
   logic [1:0]                    op_fa_ff, op_fa_in;
   logic [1:0]                    op_fb_ff, op_fb_in;
   logic [1:0]                    op_sa_ff, op_sa_in;
   logic                          zero_f_ff, zero_s_ff;
   logic signed [SAMPLE_BITS-1:0] rd_first_ff, rd_second_ff;
   logic signed [ACC_BITS-1:0]    acc_a_ff, acc_a_in;
   logic signed [ACC_BITS-1:0]    acc_b_ff, acc_b_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   result_type                    rsp_ff;
   result_type                    rsp_load_data;
   logic                          rsp_load;
   logic                          out_free;
   logic                          acc_load;
   logic                          mem_we;
   logic [ADDR_BITS-1:0]          f_addr, s_addr;
   logic [ADDR_BITS-1:0]          j_wide;
   logic [DIM_BITS-1:0]           col_next, row_next;
   logic                          has_right, has_down;

   assign out_free     = !rsp_valid_ff || rsp_pop;
   assign j_wide       = {{(ADDR_BITS-IDX_BITS){1'b0}}, index_ff};
   assign div_dividend = q_head.index;

   assign col_next  = {1'b0, div_remainder} + DIM_BITS'(1);
   assign row_next  = {1'b0, div_quotient} + DIM_BITS'(1);
   assign has_right = col_next < frame_width;
   assign has_down  = row_next < frame_height;

   // control sequence
   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      index_in      = index_ff;
      inner_in      = inner_ff;
      has_left_in   = has_left_ff;
      has_up_in     = has_up_ff;
      q_pop         = 1'b0;
      div_start     = 1'b0;
      acc_load      = 1'b0;
      mem_we        = 1'b0;
      rsp_load      = 1'b0;
      rsp_load_data = '{grad_a: '0, grad_b: '0, status: STATUS_DONE};
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               if (q_head.kind == KIND_READ) begin
                  q_pop     = 1'b1;
                  div_start = 1'b1;
                  acc_load  = 1'b1;
                  index_in  = q_head.index;
                  state_in  = ST_DIVIDE;
               end else if (out_free) begin
                  q_pop    = 1'b1;
                  rsp_load = 1'b1;
                  mem_we   = q_head.kind == KIND_WRITE;
                  rsp_load_data.status =
                     (q_head.kind == KIND_RANGE) ? STATUS_RANGE : STATUS_DONE;
               end
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               inner_in    = has_right && has_down;
               has_left_in = (div_remainder != '0) && has_down;
               has_up_in   = (div_quotient != '0) && has_right;
               step_in     = '0;
               state_in    = ST_READ;
            end
         end
         ST_READ: begin
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_LAST) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_load      = 1'b1;
               rsp_load_data = '{grad_a: sat_out(acc_a_ff), grad_b: sat_out(acc_b_ff),
                                 status: STATUS_DONE};
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // neighbor read schedule
   always_comb begin
      f_addr   = j_wide;
      s_addr   = j_wide;
      op_fa_in = TERM_NONE;
      op_fb_in = TERM_NONE;
      op_sa_in = TERM_NONE;
      if (state_ff == ST_READ) begin
         unique case (step_ff)
            2'd0: begin
               // center point
               op_fa_in = inner_ff ? TERM_SUB : TERM_NONE;
               op_fb_in = (inner_ff && !adjoint_mode) ? TERM_SUB : TERM_NONE;
               op_sa_in = (inner_ff && adjoint_mode) ? TERM_SUB : TERM_NONE;
            end
            2'd1: begin
               if (adjoint_mode) begin
                  f_addr   = j_wide - ADDR_BITS'(1);
                  s_addr   = j_wide - ADDR_BITS'(frame_width);
                  op_fa_in = has_left_ff ? TERM_ADD : TERM_NONE;
                  op_sa_in = has_up_ff ? TERM_ADD : TERM_NONE;
               end else begin
                  f_addr   = j_wide + ADDR_BITS'(1);
                  op_fa_in = inner_ff ? TERM_ADD : TERM_NONE;
               end
            end
            2'd2: begin
               if (!adjoint_mode) begin
                  f_addr   = j_wide + ADDR_BITS'(frame_width);
                  op_fb_in = inner_ff ? TERM_ADD : TERM_NONE;
               end
            end
            default: begin
               f_addr = j_wide;
            end
         endcase
      end
   end

   // accumulators
   always_comb begin
      if (acc_load) begin
         acc_a_in = accumulate_mode ?
                    {{(ACC_BITS-PRIOR_BITS){q_head.prior_a[PRIOR_BITS-1]}}, q_head.prior_a} : '0;
         acc_b_in = (accumulate_mode && !adjoint_mode) ?
                    {{(ACC_BITS-PRIOR_BITS){q_head.prior_b[PRIOR_BITS-1]}}, q_head.prior_b} : '0;
      end else begin
         acc_a_in = acc_a_ff + term(rd_first_ff, zero_f_ff, op_fa_ff)
                             + term(rd_second_ff, zero_s_ff, op_sa_ff);
         acc_b_in = acc_b_ff + term(rd_first_ff, zero_f_ff, op_fb_ff);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_pop) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         op_fa_ff     <= TERM_NONE;
         op_fb_ff     <= TERM_NONE;
         op_sa_ff     <= TERM_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         op_fa_ff     <= op_fa_in;
         op_fb_ff     <= op_fb_in;
         op_sa_ff     <= op_sa_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // neighbors at or past the end of the store read as zero
   always_ff @(posedge clock) begin
      index_ff    <= index_in;
      inner_ff    <= inner_in;
      has_left_ff <= has_left_in;
      has_up_ff   <= has_up_in;
      acc_a_ff    <= acc_a_in;
      acc_b_ff    <= acc_b_in;
      zero_f_ff   <= |f_addr[ADDR_BITS-1:IDX_BITS];
      zero_s_ff   <= |s_addr[ADDR_BITS-1:IDX_BITS];
      if (rsp_load) begin
         rsp_ff <= rsp_load_data;
      end
   end

   // single-port stores: write on a write transfer (the second store only in adjoint mode), read otherwise
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_first[q_head.index] <= SAMPLE_BITS'(q_head.value_a);
      end else begin
         rd_first_ff <= store_first[f_addr[IDX_BITS-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we && adjoint_mode) begin
         store_second[q_head.index] <= SAMPLE_BITS'(q_head.value_b);
      end else begin
         rd_second_ff <= store_second[s_addr[IDX_BITS-1:0]];
      end
   end

   assign rsp_empty = !rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ===== rtl/core/finite_difference_gradient_2d.sv =====
`timescale 1ns / 1ps
// ============================================================================
// finite_difference_gradient_2d
// Frame store with a 2-D forward-difference gradient and its adjoint.
// ============================================================================
//
// Writes load one frame point (sample, or x/y gradient pair in adjoint mode);
// reads return the forward x/y differences or the adjoint scatter sum at a
// point, optionally added to the carried prior values, saturated to 28 bits.
// An index at or past width*height answers status 1 with zero gradients and
// leaves the stores untouched. Every request gives exactly one result, in
// order. A request first passes a one-stage front end that compares the index
// against the frame size, then a two-entry queue, so pushes keep flowing
// while the back end is busy or a result is not yet popped. Writes and
// out-of-range requests are completed from the idle state once the result
// register is free. A read is picked up and starts the bit-serial row/column
// split by the frame width (12 quotient bits, then a done flag); then the
// back end does the neighbor reads from the two single-port stores, drains
// the read pipe, and saturates and loads the result register once it is free.
// Stores power up undefined; reading a point that was never written returns
// garbage. Configuration may only change while no transfer is in flight.
//
module finite_difference_gradient_2d (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                push,
   output logic                                full,
   input  logic                                req_type,
   input  logic [fdg_pkg::IDX_BITS-1:0]        req_index,
   input  logic signed [fdg_pkg::VALUE_BITS-1:0] req_value_a,
   input  logic signed [fdg_pkg::VALUE_BITS-1:0] req_value_b,
   input  logic signed [fdg_pkg::PRIOR_BITS-1:0] req_prior_a,
   input  logic signed [fdg_pkg::PRIOR_BITS-1:0] req_prior_b,
   // result channel
   output logic                                empty,
   input  logic                                pop,
   output logic signed [fdg_pkg::OUT_BITS-1:0] rsp_grad_a,
   output logic signed [fdg_pkg::OUT_BITS-1:0] rsp_grad_b,
   output logic                                rsp_status,
   // configuration channel
   input  logic                                valid,
   output logic                                ready,
   input  logic [fdg_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [fdg_pkg::CSR_DATA_BITS-1:0]   csr_data
);
   import fdg_pkg::*;

   logic [DIM_BITS-1:0]  frame_width_ff, frame_width_in;
   logic [DIM_BITS-1:0]  frame_height_ff, frame_height_in;
   logic                 adjoint_mode_ff, adjoint_mode_in;
   logic                 accumulate_mode_ff, accumulate_mode_in;

   req_item_type         req_item;
   item_type             front_item;
   item_type             q_head;
   logic                 q_push, q_full, q_pop, q_empty;

   logic                 div_start, div_done;
   logic [IDX_BITS-1:0]  div_dividend, div_quotient, div_remainder;

   result_type           rsp;

   // ---------------------------------------------------------------------
   // Configuration registers: always ready, one transfer per cycle.
   // ---------------------------------------------------------------------
   assign ready = 1'b1;

   always_comb begin
      frame_width_in     = frame_width_ff;
      frame_height_in    = frame_height_ff;
      adjoint_mode_in    = adjoint_mode_ff;
      accumulate_mode_in = accumulate_mode_ff;
      if (valid) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:     frame_width_in     = csr_data;
            CSR_FRAME_HEIGHT:    frame_height_in    = csr_data;
            CSR_ADJOINT_MODE:    adjoint_mode_in    = csr_data[0];
            CSR_ACCUMULATE_MODE: accumulate_mode_in = csr_data[0];
            default:             frame_width_in     = frame_width_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff     <= FRAME_WIDTH_RESET;
         frame_height_ff    <= FRAME_HEIGHT_RESET;
         adjoint_mode_ff    <= 1'b0;
         accumulate_mode_ff <= 1'b0;
      end else begin
         frame_width_ff     <= frame_width_in;
         frame_height_ff    <= frame_height_in;
         adjoint_mode_ff    <= adjoint_mode_in;
         accumulate_mode_ff <= accumulate_mode_in;
      end
   end

   // ---------------------------------------------------------------------
   // Front end: register, range check and classify.
   // ---------------------------------------------------------------------
   assign req_item = '{op: req_type, index: req_index, value_a: req_value_a,
                       value_b: req_value_b, prior_a: req_prior_a, prior_b: req_prior_b};

   fdg_front u_front (
      .clock        (clock),
      .reset        (reset),
      .in_push      (push),
      .in_full      (full),
      .in_item      (req_item),
      .frame_width  (frame_width_ff),
      .frame_height (frame_height_ff),
      .q_push       (q_push),
      .q_full       (q_full),
      .q_item       (front_item)
   );

   // decouples front and back so each can stall on its own
   fdg_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (front_item),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head      (q_head)
   );

   // row = index / width, column = index % width
   fdg_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (frame_width_ff),
      .done      (div_done),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   // ---------------------------------------------------------------------
   // Back end: stores, neighbor reads, accumulate and result register.
   // ---------------------------------------------------------------------
   fdg_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_head          (q_head),
      .q_pop           (q_pop),
      .frame_width     (frame_width_ff),
      .frame_height    (frame_height_ff),
      .adjoint_mode    (adjoint_mode_ff),
      .accumulate_mode (accumulate_mode_ff),
      .div_start       (div_start),
      .div_dividend    (div_dividend),
      .div_done        (div_done),
      .div_quotient    (div_quotient),
      .div_remainder   (div_remainder),
      .rsp_empty       (empty),
      .rsp_pop         (pop),
      .rsp             (rsp)
   );

   assign rsp_grad_a = rsp.grad_a;
   assign rsp_grad_b = rsp.grad_b;
   assign rsp_status = rsp.status;

endmodule

// ===== tb/sv/fdg_gradient_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// fdg_gradient_checker
// Watches the request, result and register channels of the gradient frame
// store, predicts every result from its own copy of the frame and registers,
// and compares each popped result in order.
// ============================================================================
module fdg_gradient_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  push,
   input  logic                                  full,
   input  logic                                  req_type,
   input  logic [fdg_pkg::IDX_BITS-1:0]          req_index,
   input  logic signed [fdg_pkg::VALUE_BITS-1:0] req_value_a,
   input  logic signed [fdg_pkg::VALUE_BITS-1:0] req_value_b,
   input  logic signed [fdg_pkg::PRIOR_BITS-1:0] req_prior_a,
   input  logic signed [fdg_pkg::PRIOR_BITS-1:0] req_prior_b,
   input  logic                                  empty,
   input  logic                                  pop,
   input  logic signed [fdg_pkg::OUT_BITS-1:0]   rsp_grad_a,
   input  logic signed [fdg_pkg::OUT_BITS-1:0]   rsp_grad_b,
   input  logic                                  rsp_status,
   input  logic                                  valid,
   input  logic                                  ready,
   input  logic [fdg_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [fdg_pkg::CSR_DATA_BITS-1:0]     csr_data,
   output int unsigned                           error_count,
   output int unsigned                           pending_count
);

   localparam longint GRAD_MAX = 64'sd134217727;
   localparam longint GRAD_MIN = -64'sd134217728;

   logic [fdg_pkg::DIM_BITS-1:0]          width_q;
   logic [fdg_pkg::DIM_BITS-1:0]          height_q;
   logic                                  adjoint_q;
   logic                                  accumulate_q;
   logic signed [fdg_pkg::SAMPLE_BITS-1:0] plane_first  [0:fdg_pkg::MAX_POINTS-1];
   logic signed [fdg_pkg::SAMPLE_BITS-1:0] plane_second [0:fdg_pkg::MAX_POINTS-1];
   fdg_pkg::result_type                   expected_grads [$];

   initial begin
      error_count   = 0;
      pending_count = 0;
      for (int k = 0; k < fdg_pkg::MAX_POINTS; k++) begin
         plane_first[k]  = '0;
         plane_second[k] = '0;
      end
   end

   // neighbors past the end of the store read as zero
   function automatic longint first_at(input int unsigned k);
      if (k >= fdg_pkg::MAX_POINTS) return 0;
      return longint'(plane_first[k]);
   endfunction

   function automatic longint second_at(input int unsigned k);
      if (k >= fdg_pkg::MAX_POINTS) return 0;
      return longint'(plane_second[k]);
   endfunction

   function automatic logic signed [fdg_pkg::OUT_BITS-1:0] clamp_grad(input longint v);
      if (v > GRAD_MAX) v = GRAD_MAX;
      if (v < GRAD_MIN) v = GRAD_MIN;
      return fdg_pkg::OUT_BITS'(v);
   endfunction

   // applies one request to the shadow frame and returns its result
   function automatic fdg_pkg::result_type predict_gradient(
      input logic                                  op,
      input logic [fdg_pkg::IDX_BITS-1:0]          j,
      input logic signed [fdg_pkg::VALUE_BITS-1:0] va,
      input logic signed [fdg_pkg::VALUE_BITS-1:0] vb,
      input logic signed [fdg_pkg::PRIOR_BITS-1:0] pa,
      input logic signed [fdg_pkg::PRIOR_BITS-1:0] pb
   );
      fdg_pkg::result_type r;
      int unsigned         w, h, col, row;
      longint              sum_a, sum_b, here;
      bit                  inner;
      r      = '0;
      w      = width_q;
      h      = height_q;
      sum_a  = 0;
      sum_b  = 0;
      if (j >= w * h) begin
         r.status = fdg_pkg::STATUS_RANGE;
         return r;
      end
      r.status = fdg_pkg::STATUS_DONE;
      if (op == fdg_pkg::REQ_WRITE) begin
         plane_first[j] = va;
         if (adjoint_q) plane_second[j] = vb;
         return r;
      end
      col   = j % w;
      row   = j / w;
      inner = (col + 1 < w) && (row + 1 < h);
      if (accumulate_q) begin
         sum_a = pa;
         if (!adjoint_q) sum_b = pb;
      end
      if (!adjoint_q) begin
         if (inner) begin
            here  = first_at(j);
            sum_a += first_at(j + 1) - here;
            sum_b += first_at(j + w) - here;
         end
      end else begin
         if (col >= 1 && row + 1 < h) sum_a += first_at(j - 1);
         if (row >= 1 && col + 1 < w) sum_a += second_at(j - w);
         if (inner) sum_a -= first_at(j) + second_at(j);
         sum_b = 0;
      end
      r.grad_a = clamp_grad(sum_a);
      r.grad_b = clamp_grad(sum_b);
      return r;
   endfunction

   always @(posedge clock) begin
      fdg_pkg::result_type want;
      if (reset) begin
         width_q      = fdg_pkg::FRAME_WIDTH_RESET;
         height_q     = fdg_pkg::FRAME_HEIGHT_RESET;
         adjoint_q    = 1'b0;
         accumulate_q = 1'b0;
         expected_grads.delete();
      end else begin
         if (valid && ready) begin
            case (csr_index)
               fdg_pkg::CSR_FRAME_WIDTH:     width_q      = csr_data;
               fdg_pkg::CSR_FRAME_HEIGHT:    height_q     = csr_data;
               fdg_pkg::CSR_ADJOINT_MODE:    adjoint_q    = csr_data[0];
               fdg_pkg::CSR_ACCUMULATE_MODE: accumulate_q = csr_data[0];
               default: ;
            endcase
         end
         // result transfer, compared against the oldest prediction
         if (pop && !empty) begin
            if (expected_grads.size() == 0) begin
               $display("%0t: result with nothing pending, expected none, actual %0d %0d %0d",
                        $time, rsp_grad_a, rsp_grad_b, rsp_status);
               error_count++;
            end else begin
               want = expected_grads.pop_front();
               if (rsp_grad_a !== want.grad_a) begin
                  $display("%0t: grad_a mismatch, expected %0d, actual %0d",
                           $time, want.grad_a, rsp_grad_a);
                  error_count++;
               end
               if (rsp_grad_b !== want.grad_b) begin
                  $display("%0t: grad_b mismatch, expected %0d, actual %0d",
                           $time, want.grad_b, rsp_grad_b);
                  error_count++;
               end
               if (rsp_status !== want.status) begin
                  $display("%0t: status mismatch, expected %0d, actual %0d",
                           $time, want.status, rsp_status);
                  error_count++;
               end
            end
         end
         // request transfer
         if (push && !full) begin
            expected_grads.push_back(predict_gradient(req_type, req_index, req_value_a,
                                                      req_value_b, req_prior_a, req_prior_b));
         end
      end
      pending_count = expected_grads.size();
   end

endmodule

// ===== tb/sv/tb_finite_difference_gradient_2d.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_finite_difference_gradient_2d
// Stimulus and verdict for the gradient frame store: directed corner cases,
// then randomized phases over many frame shapes and modes, with random idling
// on both channels and one long result back-pressure stretch. The checker
// beside the block predicts and compares every result.
// ============================================================================
module tb_finite_difference_gradient_2d;

   localparam int HOLD_CYCLES = 300;   // long receiver hold-off
   localparam int DRAIN_LIMIT = 5000;  // cycles allowed to empty at the end
   localparam int TAIL_CYCLES = 40;    // settle time after the last result

   localparam logic signed [fdg_pkg::VALUE_BITS-1:0] VALUE_MAX = 24'sh7FFFFF;
   localparam logic signed [fdg_pkg::VALUE_BITS-1:0] VALUE_MIN = 24'sh800000;
   localparam logic signed [fdg_pkg::PRIOR_BITS-1:0] PRIOR_MAX = 28'sh7FFFFFF;
   localparam logic signed [fdg_pkg::PRIOR_BITS-1:0] PRIOR_MIN = 28'sh8000000;

   logic                                  clock;
   logic                                  reset;
   logic                                  push;
   logic                                  full;
   logic                                  req_type;
   logic [fdg_pkg::IDX_BITS-1:0]          req_index;
   logic signed [fdg_pkg::VALUE_BITS-1:0] req_value_a;
   logic signed [fdg_pkg::VALUE_BITS-1:0] req_value_b;
   logic signed [fdg_pkg::PRIOR_BITS-1:0] req_prior_a;
   logic signed [fdg_pkg::PRIOR_BITS-1:0] req_prior_b;
   logic                                  empty;
   logic                                  pop;
   logic signed [fdg_pkg::OUT_BITS-1:0]   rsp_grad_a;
   logic signed [fdg_pkg::OUT_BITS-1:0]   rsp_grad_b;
   logic                                  rsp_status;
   logic                                  valid;
   logic                                  ready;
   logic [fdg_pkg::CSR_INDEX_BITS-1:0]    csr_index;
   logic [fdg_pkg::CSR_DATA_BITS-1:0]     csr_data;
   int unsigned                           error_count;
   int unsigned                           pending_count;

   // shadow of the register file, kept so stimulus knows the frame shape
   int unsigned frame_w;
   int unsigned frame_h;
   bit          adjoint_on;
   bit          accumulate_on;

   // which store words hold data; reads never touch a word left unwritten
   bit          written_first  [0:fdg_pkg::MAX_POINTS-1];
   bit          written_second [0:fdg_pkg::MAX_POINTS-1];

   int unsigned idle_pct;      // shared idling rate of both channels
   bit          hold_request;  // asks the receiver for one long hold-off
   int unsigned items_sent;    // random requests transferred so far
   int unsigned drain_cycles;

   finite_difference_gradient_2d u_top (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .req_type    (req_type),
      .req_index   (req_index),
      .req_value_a (req_value_a),
      .req_value_b (req_value_b),
      .req_prior_a (req_prior_a),
      .req_prior_b (req_prior_b),
      .empty       (empty),
      .pop         (pop),
      .rsp_grad_a  (rsp_grad_a),
      .rsp_grad_b  (rsp_grad_b),
      .rsp_status  (rsp_status),
      .valid       (valid),
      .ready       (ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   fdg_gradient_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .req_type      (req_type),
      .req_index     (req_index),
      .req_value_a   (req_value_a),
      .req_value_b   (req_value_b),
      .req_prior_a   (req_prior_a),
      .req_prior_b   (req_prior_b),
      .empty         (empty),
      .pop           (pop),
      .rsp_grad_a    (rsp_grad_a),
      .rsp_grad_b    (rsp_grad_b),
      .rsp_status    (rsp_status),
      .valid         (valid),
      .ready         (ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // hard stop in case the block hangs
   initial begin
      #12_000_000;
      $display("tb_finite_difference_gradient_2d: done, errors");
      $finish;
   end

   // --------------------------------------------------------------------------
   // Receiver: pops at random; when asked, holds pop low for HOLD_CYCLES so the
   // result register stays taken, the work queue backs up and full rises.
   // --------------------------------------------------------------------------
   initial begin
      pop = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            pop <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            pop <= ($urandom_range(99) >= idle_pct);
         end
      end
   end

   function automatic logic signed [fdg_pkg::VALUE_BITS-1:0] any_value();
      case ($urandom_range(7))
         0:       return VALUE_MAX;
         1:       return VALUE_MIN;
         default: return fdg_pkg::VALUE_BITS'($urandom);
      endcase
   endfunction

   function automatic logic signed [fdg_pkg::PRIOR_BITS-1:0] any_prior();
      case ($urandom_range(7))
         0:       return PRIOR_MAX;
         1:       return PRIOR_MIN;
         default: return fdg_pkg::PRIOR_BITS'($urandom);
      endcase
   endfunction

   // First store word a read at j would use that was never written, or -1.
   // Mirrors which neighbors each mode pulls in; only called for in-frame j.
   function automatic int first_missing(input int unsigned j);
      int unsigned col, row;
      bit          inner;
      col   = j % frame_w;
      row   = j / frame_w;
      inner = (col + 1 < frame_w) && (row + 1 < frame_h);
      if (!adjoint_on) begin
         if (inner) begin
            if (!written_first[j]) return j;
            if (j + 1 < fdg_pkg::MAX_POINTS && !written_first[j + 1]) return j + 1;
            if (j + frame_w < fdg_pkg::MAX_POINTS && !written_first[j + frame_w])
               return j + frame_w;
         end
      end else begin
         if (col >= 1 && row + 1 < frame_h && !written_first[j - 1]) return j - 1;
         if (row >= 1 && col + 1 < frame_w && !written_second[j - frame_w])
            return j - frame_w;
         if (inner && !(written_first[j] && written_second[j])) return j;
      end
      return -1;
   endfunction

   // One request transfer. Push stays high on return so back-to-back items
   // keep it asserted; the next call or the caller lowers it.
   task automatic send_req(
      input logic                                  op,
      input int unsigned                           idx,
      input logic signed [fdg_pkg::VALUE_BITS-1:0] va,
      input logic signed [fdg_pkg::VALUE_BITS-1:0] vb,
      input logic signed [fdg_pkg::PRIOR_BITS-1:0] pa,
      input logic signed [fdg_pkg::PRIOR_BITS-1:0] pb
   );
      while ($urandom_range(99) < idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push        <= 1'b1;
      req_type    <= op;
      req_index   <= fdg_pkg::IDX_BITS'(idx);
      req_value_a <= va;
      req_value_b <= vb;
      req_prior_a <= pa;
      req_prior_b <= pb;
      // full is settled by the falling edge; transfer is at the next rising one
      @(negedge clock);
      while (full) @(negedge clock);
      @(posedge clock);
      if (op == fdg_pkg::REQ_WRITE && idx < frame_w * frame_h) begin
         written_first[idx] = 1'b1;
         if (adjoint_on) written_second[idx] = 1'b1;
      end
   endtask

   // Register write, only once every pending result has been popped.
   task automatic write_reg(
      input logic [fdg_pkg::CSR_INDEX_BITS-1:0] idx,
      input int unsigned                        data
   );
      push <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      @(posedge clock);
      valid     <= 1'b1;
      csr_index <= idx;
      csr_data  <= fdg_pkg::CSR_DATA_BITS'(data);
      @(negedge clock);
      while (!ready) @(negedge clock);
      @(posedge clock);
      valid <= 1'b0;
      case (idx)
         fdg_pkg::CSR_FRAME_WIDTH:     frame_w       = data;
         fdg_pkg::CSR_FRAME_HEIGHT:    frame_h       = data;
         fdg_pkg::CSR_ADJOINT_MODE:    adjoint_on    = data[0];
         fdg_pkg::CSR_ACCUMULATE_MODE: accumulate_on = data[0];
         default: ;
      endcase
   endtask

   // One random request: mostly reads whose neighbors are filled in on demand,
   // plus plain writes and a share of indexes outside the frame.
   task automatic random_item();
      int unsigned pts, idx;
      int          miss;
      logic        op;
      pts = frame_w * frame_h;
      op  = ($urandom_range(99) < 55) ? fdg_pkg::REQ_READ : fdg_pkg::REQ_WRITE;
      if (pts == 0)
         idx = $urandom_range(fdg_pkg::MAX_POINTS - 1, 0);
      else if (pts < fdg_pkg::MAX_POINTS && $urandom_range(99) < 8)
         idx = $urandom_range(fdg_pkg::MAX_POINTS - 1, pts);
      else
         idx = $urandom_range(((pts < fdg_pkg::MAX_POINTS) ? pts : fdg_pkg::MAX_POINTS) - 1, 0);
      if (op == fdg_pkg::REQ_READ && idx < pts) begin
         miss = first_missing(idx);
         if (miss >= 0) begin
            op  = fdg_pkg::REQ_WRITE;
            idx = miss;
         end
      end
      send_req(op, idx, any_value(), any_value(), any_prior(), any_prior());
   endtask

   task automatic run_phase(
      input int unsigned w, input int unsigned h,
      input int unsigned adj, input int unsigned acc, input int unsigned n
   );
      write_reg(fdg_pkg::CSR_FRAME_WIDTH, w);
      write_reg(fdg_pkg::CSR_FRAME_HEIGHT, h);
      write_reg(fdg_pkg::CSR_ADJOINT_MODE, adj);
      write_reg(fdg_pkg::CSR_ACCUMULATE_MODE, acc);
      repeat (n) begin
         // one stretch with no idling on either side
         idle_pct = (items_sent >= 300 && items_sent < 600) ? 0 : 14;
         if (items_sent == 120) hold_request = 1'b1;
         random_item();
         items_sent++;
      end
   endtask

   initial begin
      reset         = 1'b1;
      push          = 1'b0;
      req_type      = fdg_pkg::REQ_WRITE;
      req_index     = '0;
      req_value_a   = '0;
      req_value_b   = '0;
      req_prior_a   = '0;
      req_prior_b   = '0;
      valid         = 1'b0;
      csr_index     = fdg_pkg::CSR_FRAME_WIDTH;
      csr_data      = '0;
      frame_w       = 32'(fdg_pkg::FRAME_WIDTH_RESET);
      frame_h       = 32'(fdg_pkg::FRAME_HEIGHT_RESET);
      adjoint_on    = 1'b0;
      accumulate_on = 1'b0;
      idle_pct      = 14;
      hold_request  = 1'b0;
      items_sent    = 0;
      drain_cycles  = 0;
      for (int k = 0; k < fdg_pkg::MAX_POINTS; k++) begin
         written_first[k]  = 1'b0;
         written_second[k] = 1'b0;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // ---- directed: reset shape 64x64, forward, no accumulate ----
      // full-scale opposite samples give the largest negative differences
      send_req(fdg_pkg::REQ_WRITE, 0,    VALUE_MAX, VALUE_MIN, PRIOR_MAX, PRIOR_MIN);
      send_req(fdg_pkg::REQ_WRITE, 1,    VALUE_MIN, VALUE_MAX, PRIOR_MIN, PRIOR_MAX);
      send_req(fdg_pkg::REQ_WRITE, 64,   VALUE_MIN, VALUE_MAX, PRIOR_MAX, PRIOR_MAX);
      send_req(fdg_pkg::REQ_READ,  0,    VALUE_MAX, VALUE_MAX, PRIOR_MAX, PRIOR_MAX);
      // last column and last row read as zero differences
      send_req(fdg_pkg::REQ_READ,  63,   VALUE_MIN, VALUE_MIN, PRIOR_MIN, PRIOR_MIN);
      send_req(fdg_pkg::REQ_WRITE, 4095, VALUE_MAX, VALUE_MAX, PRIOR_MIN, PRIOR_MIN);
      send_req(fdg_pkg::REQ_READ,  4095, VALUE_MIN, VALUE_MAX, PRIOR_MAX, PRIOR_MIN);

      // accumulate: push the prior past both output rails
      write_reg(fdg_pkg::CSR_ACCUMULATE_MODE, 1);
      send_req(fdg_pkg::REQ_READ,  0,    VALUE_MIN, VALUE_MIN, PRIOR_MIN, PRIOR_MIN);
      send_req(fdg_pkg::REQ_WRITE, 0,    VALUE_MIN, VALUE_MIN, PRIOR_MAX, PRIOR_MAX);
      send_req(fdg_pkg::REQ_WRITE, 1,    VALUE_MAX, VALUE_MIN, PRIOR_MAX, PRIOR_MAX);
      send_req(fdg_pkg::REQ_WRITE, 64,   VALUE_MAX, VALUE_MIN, PRIOR_MAX, PRIOR_MAX);
      send_req(fdg_pkg::REQ_READ,  0,    VALUE_MAX, VALUE_MAX, PRIOR_MAX, PRIOR_MAX);
      send_req(fdg_pkg::REQ_READ,  4095, VALUE_MAX, VALUE_MIN, PRIOR_MAX, PRIOR_MIN);

      // ---- directed: 4x3 adjoint, interior point and edges ----
      write_reg(fdg_pkg::CSR_FRAME_WIDTH, 4);
      write_reg(fdg_pkg::CSR_FRAME_HEIGHT, 3);
      write_reg(fdg_pkg::CSR_ADJOINT_MODE, 1);
      write_reg(fdg_pkg::CSR_ACCUMULATE_MODE, 0);
      send_req(fdg_pkg::REQ_WRITE, 1,    VALUE_MAX, VALUE_MAX, PRIOR_MIN, PRIOR_MIN);
      send_req(fdg_pkg::REQ_WRITE, 4,    VALUE_MAX, VALUE_MAX, PRIOR_MIN, PRIOR_MIN);
      send_req(fdg_pkg::REQ_WRITE, 5,    VALUE_MIN, VALUE_MIN, PRIOR_MAX, PRIOR_MAX);
      send_req(fdg_pkg::REQ_READ,  5,    VALUE_MIN, VALUE_MAX, PRIOR_MAX, PRIOR_MAX);
      // corner point has no contributing neighbor
      send_req(fdg_pkg::REQ_READ,  11,   VALUE_MAX, VALUE_MIN, PRIOR_MAX, PRIOR_MIN);
      // outside the frame: status set, write dropped
      send_req(fdg_pkg::REQ_WRITE, 12,   VALUE_MAX, VALUE_MAX, PRIOR_MAX, PRIOR_MAX);
      send_req(fdg_pkg::REQ_READ,  4095, VALUE_MIN, VALUE_MIN, PRIOR_MIN, PRIOR_MIN);
      // accumulate on top of a full-scale adjoint sum saturates high
      write_reg(fdg_pkg::CSR_ACCUMULATE_MODE, 1);
      send_req(fdg_pkg::REQ_READ,  5,    VALUE_MAX, VALUE_MAX, PRIOR_MAX, PRIOR_MAX);

      // ---- random phases over frame shapes and modes ----
      run_phase(8, 8, 0, 0, 200);
      run_phase(8, 8, 1, 1, 200);
      run_phase(1, 4096, 0, 1, 100);          // single column: no interior points
      run_phase(4096, 1, 1, 0, 100);          // single row
      run_phase(4096, 4096, 0, 1, 100);       // frame larger than the store
      run_phase(64, 64, 1, 1, 100);
      repeat (6) begin
         run_phase($urandom_range(16, 1), $urandom_range(16, 1),
                   $urandom_range(1), $urandom_range(1), 150);
      end
      run_phase(0, 64, 1, 0, 30);             // zero width: every index out of frame
      run_phase(64, 0, 0, 1, 20);             // zero height

      // ---- drain and verdict ----
      push <= 1'b0;
      @(negedge clock);
      while (pending_count != 0 && drain_cycles < DRAIN_LIMIT) begin
         @(negedge clock);
         drain_cycles++;
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_count == 0) begin
         $display("tb_finite_difference_gradient_2d: done, clean");
      end else begin
         $display("tb_finite_difference_gradient_2d: done, errors");
      end
      $finish;
   end

endmodule
